FILE: hdl/gsm_pkg.sv
package gsm_pkg;

  localparam int unsigned INDEX_W = 6;
  localparam int unsigned WORD_W  = 32;
  // Counts are compared against a handle index in this width.
  localparam int unsigned CMP_W   = 7;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_EMIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_STALE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] handle_index;
    logic [WORD_W-1:0]  handle_generation;
    logic [WORD_W-1:0]  listener_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] out_index;
    logic [WORD_W-1:0]  out_generation;
    logic [WORD_W-1:0]  out_data;
    logic               last;
  } out_item_t;

endpackage

FILE: hdl/gsm_ram.sv
module gsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/generational_slot_map.sv
// Generational handle table with up to SLOTS entries. Each item is one of add,
// remove, query or emit; the block works on one item at a time and takes the
// next item as soon as the previous result sits in the output register. State
// lives in two single-port-write RAMs with registered read data: a slot RAM
// (generation, dense position, live bit; freed slots chain through the
// position field as the free stack) and a dense RAM (payload, owning slot).
// An add with a fresh slot writes both RAMs; an add reusing a freed slot first
// reads the free-list head from the slot RAM; query and remove read the slot
// and check it. Removing a non-last entry also moves the last dense entry and
// fixes its slot's position (a dense read then a slot read-modify-write). Emit
// streams one payload per cycle from the dense RAM when the output is not
// stalled. Full table returns status 2; stale handles return status 1.
module generational_slot_map #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned GEN_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gsm_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsm_pkg::out_item_t   out_item
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned GW = GEN_BITS;
  localparam int unsigned DW = (DATA_BITS > gsm_pkg::WORD_W) ? gsm_pkg::WORD_W : DATA_BITS;

  typedef struct packed {
    logic          live;
    logic [GW-1:0] gen;
    logic [SW-1:0] pos;   // dense position when live, free-list link when not
  } slot_ent_t;

  typedef struct packed {
    logic [DW-1:0] data;
    logic [SW-1:0] slot;
  } dense_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_POP,
    S_CHK,
    S_RM_MOVE,
    S_RM_FIX,
    S_RESP,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  gsm_pkg::in_item_t  item_r, item_nxt;
  gsm_pkg::out_item_t res_r, res_nxt;
  gsm_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CW-1:0]      slot_count_r, slot_count_nxt;
  logic [CW-1:0]      live_count_r, live_count_nxt;
  logic [CW-1:0]      free_count_r, free_count_nxt;
  logic [SW-1:0]      free_head_r, free_head_nxt;
  logic [SW-1:0]      pos_r, pos_nxt;
  logic [SW-1:0]      moved_r, moved_nxt;
  logic [SW-1:0]      emit_idx_r, emit_idx_nxt;

  logic               slot_we, slot_re;
  logic [SW-1:0]      slot_waddr, slot_raddr;
  slot_ent_t          slot_wdata, slot_rdata;
  logic               dense_we, dense_re;
  logic [SW-1:0]      dense_waddr, dense_raddr;
  dense_ent_t         dense_wdata, dense_rdata;

  logic               out_free;
  logic               hit;
  logic               emit_last;
  logic [SW-1:0]      last_pos;

  gsm_ram #(
    .WIDTH($bits(slot_ent_t)),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  gsm_ram #(
    .WIDTH($bits(dense_ent_t)),
    .DEPTH(SLOTS)
  ) u_dense_ram (
    .clk  (clk),
    .we   (dense_we),
    .waddr(dense_waddr),
    .wdata(dense_wdata),
    .re   (dense_re),
    .raddr(dense_raddr),
    .rdata(dense_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign hit = ({1'b0, item_r.handle_index} < gsm_pkg::CMP_W'(slot_count_r))
               && slot_rdata.live
               && (gsm_pkg::WORD_W'(slot_rdata.gen) == item_r.handle_generation);
  assign last_pos  = SW'(live_count_r - 1'b1);
  assign emit_last = (CW'(emit_idx_r) + CW'(1)) == live_count_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    slot_count_nxt = slot_count_r;
    live_count_nxt = live_count_r;
    free_count_nxt = free_count_r;
    free_head_nxt  = free_head_r;
    pos_nxt        = pos_r;
    moved_nxt      = moved_r;
    emit_idx_nxt   = emit_idx_r;
    slot_we        = 1'b0;
    slot_waddr     = '0;
    slot_wdata     = '0;
    slot_re        = 1'b0;
    slot_raddr     = '0;
    dense_we       = 1'b0;
    dense_waddr    = '0;
    dense_wdata    = '0;
    dense_re       = 1'b0;
    dense_raddr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_item;
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          case (in_item.kind) inside
            gsm_pkg::KIND_ADD: begin
              if (live_count_r == CW'(SLOTS)) begin
                res_nxt.status = gsm_pkg::STAT_FULL;
                state_nxt      = S_RESP;
              end else if (free_count_r != '0) begin
                slot_re    = 1'b1;
                slot_raddr = free_head_r;
                state_nxt  = S_ADD_POP;
              end else begin
                // Fresh slot, generation zero.
                slot_we          = 1'b1;
                slot_waddr       = slot_count_r[SW-1:0];
                slot_wdata.live  = 1'b1;
                slot_wdata.gen   = '0;
                slot_wdata.pos   = live_count_r[SW-1:0];
                dense_we         = 1'b1;
                dense_waddr      = live_count_r[SW-1:0];
                dense_wdata.data = in_item.listener_data[DW-1:0];
                dense_wdata.slot = slot_count_r[SW-1:0];
                slot_count_nxt   = slot_count_r + 1'b1;
                live_count_nxt   = live_count_r + 1'b1;
                res_nxt.out_index = gsm_pkg::INDEX_W'(slot_count_r[SW-1:0]);
                state_nxt        = S_RESP;
              end
            end
            gsm_pkg::KIND_REMOVE, gsm_pkg::KIND_QUERY: begin
              slot_re    = 1'b1;
              slot_raddr = in_item.handle_index[SW-1:0];
              state_nxt  = S_CHK;
            end
            default: begin
              if (live_count_r == '0) begin
                res_nxt.status = gsm_pkg::STAT_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                dense_re     = 1'b1;
                dense_raddr  = '0;
                emit_idx_nxt = '0;
                state_nxt    = S_EMIT;
              end
            end
          endcase
        end
      end

      S_ADD_POP: begin
        // Pop the free-list head, keep its generation.
        slot_we           = 1'b1;
        slot_waddr        = free_head_r;
        slot_wdata.live   = 1'b1;
        slot_wdata.gen    = slot_rdata.gen;
        slot_wdata.pos    = live_count_r[SW-1:0];
        dense_we          = 1'b1;
        dense_waddr       = live_count_r[SW-1:0];
        dense_wdata.data  = item_r.listener_data[DW-1:0];
        dense_wdata.slot  = free_head_r;
        free_head_nxt     = slot_rdata.pos;
        free_count_nxt    = free_count_r - 1'b1;
        live_count_nxt    = live_count_r + 1'b1;
        res_nxt.out_index = gsm_pkg::INDEX_W'(free_head_r);
        res_nxt.out_generation = gsm_pkg::WORD_W'(slot_rdata.gen);
        state_nxt         = S_RESP;
      end

      S_CHK: begin
        state_nxt = S_RESP;
        if (!hit) begin
          res_nxt.status = gsm_pkg::STAT_STALE;
        end else if (item_r.kind == gsm_pkg::KIND_REMOVE) begin
          // Free the slot: bump generation, push onto the free list.
          slot_we         = 1'b1;
          slot_waddr      = item_r.handle_index[SW-1:0];
          slot_wdata.live = 1'b0;
          slot_wdata.gen  = slot_rdata.gen + 1'b1;
          slot_wdata.pos  = free_head_r;
          free_head_nxt   = item_r.handle_index[SW-1:0];
          free_count_nxt  = free_count_r + 1'b1;
          live_count_nxt  = live_count_r - 1'b1;
          pos_nxt         = slot_rdata.pos;
          if (slot_rdata.pos != last_pos) begin
            dense_re    = 1'b1;
            dense_raddr = last_pos;
            state_nxt   = S_RM_MOVE;
          end
        end
      end

      S_RM_MOVE: begin
        // Fill the hole with the last dense entry.
        dense_we    = 1'b1;
        dense_waddr = pos_r;
        dense_wdata = dense_rdata;
        slot_re     = 1'b1;
        slot_raddr  = dense_rdata.slot;
        moved_nxt   = dense_rdata.slot;
        state_nxt   = S_RM_FIX;
      end

      S_RM_FIX: begin
        slot_we         = 1'b1;
        slot_waddr      = moved_r;
        slot_wdata.live = 1'b1;
        slot_wdata.gen  = slot_rdata.gen;
        slot_wdata.pos  = pos_r;
        state_nxt       = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt            = '0;
          out_item_nxt.status     = gsm_pkg::STAT_OK;
          out_item_nxt.out_data   = gsm_pkg::WORD_W'(dense_rdata.data);
          out_item_nxt.last       = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            dense_re     = 1'b1;
            dense_raddr  = SW'(emit_idx_r + 1'b1);
            emit_idx_nxt = SW'(emit_idx_r + 1'b1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      slot_count_r <= '0;
      live_count_r <= '0;
      free_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      slot_count_r <= slot_count_nxt;
      live_count_r <= live_count_nxt;
      free_count_r <= free_count_nxt;
    end
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_item_r  <= out_item_nxt;
    free_head_r <= free_head_nxt;
    pos_r       <= pos_nxt;
    moved_r     <= moved_nxt;
    emit_idx_r  <= emit_idx_nxt;
  end

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(live_count_r) + (CW + 1)'(free_count_r) == (CW + 1)'(slot_count_r))
    else $error("live plus free slots differ from slots in use");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_count_r <= CW'(SLOTS))
    else $error("slot count above table size");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (CW'(emit_idx_r) < live_count_r))
    else $error("emit walks past live entries");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> (out_valid_r && out_item_r.last))
    else $error("single result not presented");

endmodule
